### rtl/rse_pkg.sv
// Shared types, constants and helpers for the replacement escape scanner.
// No dependencies; every other file refers to this package by scoped names.
package rse_pkg;

   // Width of every count field and of the backslash run
   localparam int CNT_W = 13;

   // Length bound of one string; counts stop at the smaller of this and 8191
   localparam int MAX_LEN = 4096;
   localparam logic [CNT_W-1:0] LIMIT = CNT_W'((MAX_LEN < 8191) ? MAX_LEN : 8191);

   // Depth of the token queue in front of the result port
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Special bytes
   localparam logic [7:0] CHAR_AMP = 8'h26;
   localparam logic [7:0] CHAR_BSL = 8'h5C;

   // Scan modes
   localparam logic MODE_CLASSIC = 1'b0;
   localparam logic MODE_POSIX   = 1'b1;

   typedef enum logic [1:0] {
      KIND_LIT  = 2'd0,
      KIND_MARK = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   // One result token
   typedef struct packed {
      kind_type         kind;
      logic [7:0]       lit_byte;
      logic [CNT_W-1:0] rep;
      logic             eos;
      logic [CNT_W-1:0] mk_total;
      logic [CNT_W-1:0] lit_total;
      logic             ovf;
   } tok_type;

   // Tokens produced by one item: an optional leading backslash run and the main token
   typedef struct packed {
      logic    has_a;
      logic    has_b;
      tok_type tok_a;
      tok_type tok_b;
   } scan_push_type;

   // Saturating add: bit CNT_W flags that the bound was passed
   function automatic logic [CNT_W:0] sat_add(input logic [CNT_W-1:0] a,
                                              input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s > {1'b0, LIMIT}) begin
         return {1'b1, LIMIT};
      end
      return {1'b0, s[CNT_W-1:0]};
   endfunction

endpackage

### rtl/rse_scan.sv
// Scan stage: holds the mode register and per-string state, turns one item into
// up to two tokens in a single pass. Depends on rse_pkg.
module rse_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_mode,
   input  logic                  item_go,
   input  logic [7:0]            item_char,
   input  logic                  item_end_only,
   input  logic                  item_is_last,
   output rse_pkg::scan_push_type push
);

   logic                        mode_ff;
   logic [rse_pkg::CNT_W-1:0]   run_ff, run_in;
   logic [rse_pkg::CNT_W-1:0]   mk_ff, mk_in;
   logic [rse_pkg::CNT_W-1:0]   lit_ff, lit_in;
   logic                        sat_ff, sat_in;

   logic                        ending;
   logic                        is_amp, is_bsl;
   logic                        a_en, b_en;
   logic [rse_pkg::CNT_W-1:0]   a_rep, b_rep;
   rse_pkg::kind_type           b_kind;
   logic [7:0]                  b_byte;
   logic [rse_pkg::CNT_W-1:0]   run_nx;
   logic                        sat0, sat_a;
   logic [rse_pkg::CNT_W-1:0]   lit_a;
   logic [rse_pkg::CNT_W:0]     sum_a, sum_b, sum_m;

   assign ending = item_end_only | item_is_last;
   assign is_amp = (item_char == rse_pkg::CHAR_AMP);
   assign is_bsl = (item_char == rse_pkg::CHAR_BSL);

   // Decode the item against the pending run
   always_comb begin
      a_en   = 1'b0;
      a_rep  = run_ff;
      b_en   = 1'b0;
      b_kind = rse_pkg::KIND_LIT;
      b_byte = item_char;
      b_rep  = rse_pkg::CNT_W'(1);
      run_nx = run_ff;
      sat0   = sat_ff;
      if (item_end_only) begin
         b_en   = 1'b1;
         run_nx = '0;
         if (run_ff != '0) begin
            b_byte = rse_pkg::CHAR_BSL;
            b_rep  = run_ff;
         end else begin
            b_kind = rse_pkg::KIND_END;
            b_byte = '0;
            b_rep  = '0;
         end
      end else if (mode_ff == rse_pkg::MODE_CLASSIC) begin
         if (is_bsl) begin
            if (run_ff < rse_pkg::LIMIT) begin
               run_nx = run_ff + rse_pkg::CNT_W'(1);
            end else begin
               sat0 = 1'b1;
            end
            if (ending) begin
               b_en   = 1'b1;
               b_byte = rse_pkg::CHAR_BSL;
               b_rep  = run_nx;
               run_nx = '0;
            end
         end else if (is_amp) begin
            a_en   = (run_ff[rse_pkg::CNT_W-1:1] != '0);
            a_rep  = {1'b0, run_ff[rse_pkg::CNT_W-1:1]};
            b_en   = 1'b1;
            run_nx = '0;
            if (!run_ff[0]) begin
               b_kind = rse_pkg::KIND_MARK;
               b_byte = '0;
               b_rep  = '0;
            end
         end else begin
            a_en   = (run_ff != '0);
            b_en   = 1'b1;
            run_nx = '0;
         end
      end else begin
         if (run_ff != '0) begin
            a_en   = !(is_amp || is_bsl);
            a_rep  = rse_pkg::CNT_W'(1);
            b_en   = 1'b1;
            run_nx = '0;
         end else if (is_amp) begin
            b_en   = 1'b1;
            b_kind = rse_pkg::KIND_MARK;
            b_byte = '0;
            b_rep  = '0;
         end else if (is_bsl) begin
            run_nx = rse_pkg::CNT_W'(1);
            if (ending) begin
               b_en   = 1'b1;
               b_byte = rse_pkg::CHAR_BSL;
               run_nx = '0;
            end
         end else begin
            b_en = 1'b1;
         end
      end
   end

   // Update the totals in token order
   always_comb begin
      sum_a  = rse_pkg::sat_add(lit_ff, a_rep);
      lit_a  = a_en ? sum_a[rse_pkg::CNT_W-1:0] : lit_ff;
      sat_a  = sat0 | (a_en & sum_a[rse_pkg::CNT_W]);
      sum_b  = rse_pkg::sat_add(lit_a, b_rep);
      sum_m  = rse_pkg::sat_add(mk_ff, rse_pkg::CNT_W'(1));
      lit_in = lit_a;
      mk_in  = mk_ff;
      sat_in = sat_a;
      if (b_en && b_kind == rse_pkg::KIND_LIT) begin
         lit_in = sum_b[rse_pkg::CNT_W-1:0];
         sat_in = sat_a | sum_b[rse_pkg::CNT_W];
      end else if (b_en && b_kind == rse_pkg::KIND_MARK) begin
         mk_in  = sum_m[rse_pkg::CNT_W-1:0];
         sat_in = sat_a | sum_m[rse_pkg::CNT_W];
      end
      run_in = run_nx;
   end

   // Build the tokens
   always_comb begin
      push.has_a           = item_go & a_en;
      push.has_b           = item_go & b_en;
      push.tok_a.kind      = rse_pkg::KIND_LIT;
      push.tok_a.lit_byte  = rse_pkg::CHAR_BSL;
      push.tok_a.rep       = a_rep;
      push.tok_a.eos       = 1'b0;
      push.tok_a.mk_total  = '0;
      push.tok_a.lit_total = '0;
      push.tok_a.ovf       = sat_a;
      push.tok_b.kind      = b_kind;
      push.tok_b.lit_byte  = b_byte;
      push.tok_b.rep       = b_rep;
      push.tok_b.eos       = ending;
      push.tok_b.mk_total  = ending ? mk_in : '0;
      push.tok_b.lit_total = ending ? lit_in : '0;
      push.tok_b.ovf       = sat_in;
   end

   // Hold mode and per-string state; clear on string end or mode write
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rse_pkg::MODE_CLASSIC;
         run_ff  <= '0;
         mk_ff   <= '0;
         lit_ff  <= '0;
         sat_ff  <= 1'b0;
      end else if (csr_we) begin
         mode_ff <= csr_mode;
         run_ff  <= '0;
         mk_ff   <= '0;
         lit_ff  <= '0;
         sat_ff  <= 1'b0;
      end else if (item_go) begin
         if (ending) begin
            run_ff <= '0;
            mk_ff  <= '0;
            lit_ff <= '0;
            sat_ff <= 1'b0;
         end else begin
            run_ff <= run_in;
            mk_ff  <= mk_in;
            lit_ff <= lit_in;
            sat_ff <= sat_in;
         end
      end
   end

   // The run never passes the bound
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff <= rse_pkg::LIMIT)
      else $error("backslash run above bound");

   // Posix mode holds at most one pending backslash
   a_posix_run: assert property (@(posedge clock) disable iff (reset)
      mode_ff == rse_pkg::MODE_POSIX |-> run_ff <= rse_pkg::CNT_W'(1))
      else $error("posix run above one");

   // A processed end leaves clean state behind
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      item_go && ending && !csr_we |=> run_ff == '0 && mk_ff == '0 && lit_ff == '0 && !sat_ff)
      else $error("state not cleared after string end");

   // An ending item always yields a final token
   a_end_token: assert property (@(posedge clock) disable iff (reset)
      item_go && ending |-> push.has_b)
      else $error("string end without final token");

endmodule

### rtl/rse_tok_queue.sv
// Token queue: shift-style buffer that takes up to two tokens per cycle and
// presents its head to the result port. Depends on rse_pkg.
module rse_tok_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  rse_pkg::scan_push_type push,
   input  logic                   pop,
   output logic                   room,
   output logic                   not_empty,
   output rse_pkg::tok_type       head
);

   rse_pkg::tok_type           ent_ff [rse_pkg::QUEUE_DEPTH];
   rse_pkg::tok_type           ent_in [rse_pkg::QUEUE_DEPTH];
   logic [rse_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic [rse_pkg::QCNT_W-1:0] base;
   logic [rse_pkg::QCNT_W-1:0] n_push;

   assign not_empty = (cnt_ff != '0);
   assign room      = (cnt_ff <= rse_pkg::QCNT_W'(rse_pkg::QUEUE_DEPTH - 2));
   assign head      = ent_ff[0];
   assign base      = cnt_ff - rse_pkg::QCNT_W'(pop);
   assign n_push    = rse_pkg::QCNT_W'(push.has_a) + rse_pkg::QCNT_W'(push.has_b);
   assign cnt_in    = base + n_push;

   // Shift on pop, then drop new tokens in behind the survivors
   always_comb begin
      for (int i = 0; i < rse_pkg::QUEUE_DEPTH; i++) begin
         if (pop && i < rse_pkg::QUEUE_DEPTH - 1) begin
            ent_in[i] = ent_ff[i+1];
         end else begin
            ent_in[i] = ent_ff[i];
         end
         if (push.has_b && base == rse_pkg::QCNT_W'(i)) begin
            ent_in[i] = push.has_a ? push.tok_a : push.tok_b;
         end
         if (push.has_a && base + rse_pkg::QCNT_W'(1) == rse_pkg::QCNT_W'(i)) begin
            ent_in[i] = push.tok_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Fill never exceeds depth
   a_fill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= rse_pkg::QCNT_W'(rse_pkg::QUEUE_DEPTH))
      else $error("token queue overfilled");

   // A leading token never comes without the main one
   a_pair: assert property (@(posedge clock) disable iff (reset)
      push.has_a |-> push.has_b)
      else $error("leading token without main token");

   // Tokens are pushed only when there was room
   a_room: assert property (@(posedge clock) disable iff (reset)
      push.has_b |-> room)
      else $error("push into full queue");

endmodule

### rtl/replacement_escape_scanner_top.sv
// Top level of the replacement escape scanner: input register, scan stage and
// token queue. Depends on rse_pkg, rse_scan and rse_tok_queue.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | char_code, end_only, is_last
//   rsp_    | out       | rsp_valid/rsp_stall | token fields, totals, overflow
//   csr_    | in        | csr_valid/csr_ready | scan_mode
//
// One byte per cycle enters the input register while req_stall is low; the
// scan stage takes it when the queue has room and writes zero, one or two
// tokens to a four-entry queue. The result port moves one token per cycle
// while rsp_stall is low, so items that yield two tokens set the sustained
// rate when they dominate. Reset clears mode (classic) and all string state.
// Input stalls while an item is held and under two queue entries are free.
module replacement_escape_scanner_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_only,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_token_kind,
   output logic [7:0]  rsp_literal_byte,
   output logic [12:0] rsp_repeat_count,
   output logic        rsp_end_of_string,
   output logic [12:0] rsp_marker_total,
   output logic [12:0] rsp_literal_total,
   output logic        rsp_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_scan_mode
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_char_ff;
   logic                   in_end_only_ff;
   logic                   in_is_last_ff;
   logic                   req_xfer;
   logic                   item_go;
   logic                   room;
   logic                   rsp_xfer;
   rse_pkg::scan_push_type push;
   rse_pkg::tok_type       head;

   // Item advances to the scan stage when the queue can take two tokens
   assign item_go   = in_valid_ff & room;
   assign req_stall = in_valid_ff & ~room;
   assign req_xfer  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign rsp_xfer  = rsp_valid & ~rsp_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (item_go) begin
         in_valid_in = 1'b0;
      end
   end

   // Hold the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_char_ff     <= req_char_code;
         in_end_only_ff <= req_end_only;
         in_is_last_ff  <= req_is_last;
      end
   end

   rse_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_valid & csr_ready),
      .csr_mode      (csr_scan_mode),
      .item_go       (item_go),
      .item_char     (in_char_ff),
      .item_end_only (in_end_only_ff),
      .item_is_last  (in_is_last_ff),
      .push          (push)
   );

   rse_tok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_xfer),
      .room      (room),
      .not_empty (rsp_valid),
      .head      (head)
   );

   // Drive the result payload from the queue head
   assign rsp_token_kind    = head.kind;
   assign rsp_literal_byte  = head.lit_byte;
   assign rsp_repeat_count  = head.rep;
   assign rsp_end_of_string = head.eos;
   assign rsp_marker_total  = head.mk_total;
   assign rsp_literal_total = head.lit_total;
   assign rsp_overflow      = head.ovf;

endmodule
